### src/smc_pkg.sv
// Shared types and constants for the segment mean color block.
package smc_pkg;

  localparam int MaxLabelsDefault = 1024;
  localparam int PixelCountBitsDefault = 20;
  localparam int LabelW = 10;
  localparam int ChanW = 8;
  localparam int NumChan = 3;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_PAINT = 2'd2,
    CMD_NONE  = 2'd3
  } smc_cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LabelW-1:0] label;
    logic [ChanW-1:0]  in_blue;
    logic [ChanW-1:0]  in_green;
    logic [ChanW-1:0]  in_red;
  } smc_in_t;

  typedef struct packed {
    logic [ChanW-1:0] mean_blue;
    logic [ChanW-1:0] mean_green;
    logic [ChanW-1:0] mean_red;
  } smc_out_t;

endpackage

### src/smc_mem.sv
// Per-label statistics memory: one write port, one registered read port.
module smc_mem import smc_pkg::*; #(
  parameter int Depth = 1024,
  parameter int DataW = 105
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [DataW-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [DataW-1:0]         rdata
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/smc_div.sv
// Three-channel restoring divider, one quotient bit per cycle.
module smc_div import smc_pkg::*; #(
  parameter int PixelCountBits = PixelCountBitsDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [PixelCountBits+7:0]   sum_blue,
  input  logic [PixelCountBits+7:0]   sum_green,
  input  logic [PixelCountBits+7:0]   sum_red,
  input  logic [PixelCountBits:0]     count,
  output logic                        done,
  output smc_out_t                    means
);

  localparam int SumW = PixelCountBits + 8;

  logic [SumW-1:0]  rem_r [NumChan];
  logic [SumW-1:0]  rem_nxt [NumChan];
  logic [ChanW-1:0] q_r [NumChan];
  logic [ChanW-1:0] q_nxt [NumChan];
  logic [SumW-1:0]  dsr_r;
  logic [2:0]       step_r;
  logic             busy_r;
  logic             done_r;
  logic             zero_r;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (rem_r[c] >= dsr_r) begin
        rem_nxt[c] = rem_r[c] - dsr_r;
        q_nxt[c]   = {q_r[c][ChanW-2:0], 1'b1};
      end else begin
        rem_nxt[c] = rem_r[c];
        q_nxt[c]   = {q_r[c][ChanW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= !start && busy_r && (step_r == 3'd7);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd7) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r[0] <= sum_blue;
      rem_r[1] <= sum_green;
      rem_r[2] <= sum_red;
      for (int c = 0; c < NumChan; c++) begin
        q_r[c] <= '0;
      end
      dsr_r  <= {count, 7'd0};
      zero_r <= (count == '0);
    end else if (busy_r) begin
      for (int c = 0; c < NumChan; c++) begin
        rem_r[c] <= rem_nxt[c];
        q_r[c]   <= q_nxt[c];
      end
      dsr_r <= dsr_r >> 1;
    end
  end

  // An empty segment paints as black.
  assign means.mean_blue  = zero_r ? '0 : q_r[0];
  assign means.mean_green = zero_r ? '0 : q_r[1];
  assign means.mean_red   = zero_r ? '0 : q_r[2];
  assign done = done_r;

endmodule

### src/segment_mean_color_core.sv
// Segment mean color core: per-label color sums and counts with mean readout.
// One beat at a time: clear is a single memory write, accumulate a memory read,
// then a write back, and paint a memory read, divider load, the quotient steps of
// the bit-serial divider, a step to see it finish, then the output register.
// A paint result waits in the output register while the next beat is already
// accepted; a second paint waits before the output register for as long as the
// earlier result is stalled. Memory contents are undefined after reset;
// a label must be cleared before it is accumulated or painted.
module segment_mean_color_core import smc_pkg::*; #(
  parameter int MaxLabels = MaxLabelsDefault,
  parameter int PixelCountBits = PixelCountBitsDefault
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  smc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output smc_out_t out_data
);

  localparam int Depth = (MaxLabels < (1 << LabelW)) ? MaxLabels : (1 << LabelW);
  localparam int AddrW = $clog2(Depth);
  localparam int SumW = PixelCountBits + 8;
  localparam int CntW = PixelCountBits + 1;
  localparam int DataW = 3 * SumW + CntW;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_HOLD} state_t;

  state_t           state_r;
  logic [1:0]       cmd_r;
  logic [AddrW-1:0] addr_r;
  logic [ChanW-1:0] pix_r [NumChan];
  logic             out_valid_r;
  smc_out_t         out_data_r;

  logic             in_acc;
  logic             in_range;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [DataW-1:0] mem_rdata;
  logic [SumW-1:0]  rd_blue, rd_green, rd_red;
  logic [CntW-1:0]  rd_count;
  logic             div_start;
  logic             div_done;
  smc_out_t         div_means;
  logic             out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign in_range = (32'(in_data.label) < MaxLabels);
  assign out_free = !out_valid_r || !out_stall;

  assign {rd_count, rd_blue, rd_green, rd_red} = mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;
    if (in_acc && in_range && in_data.cmd == CMD_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = in_data.label[AddrW-1:0];
    end else if (state_r == S_READ && cmd_r == CMD_ACCUM && !rd_count[CntW-1]) begin
      // Count below the limit: add the pixel; at the limit the entry stays.
      mem_we    = 1'b1;
      mem_wdata = {rd_count + CntW'(1),
                   rd_blue + SumW'(pix_r[0]),
                   rd_green + SumW'(pix_r[1]),
                   rd_red + SumW'(pix_r[2])};
    end
  end

  assign div_start = (state_r == S_READ) && (cmd_r == CMD_PAINT);

  smc_mem #(.Depth(Depth), .DataW(DataW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_data.label[AddrW-1:0]),
    .rdata (mem_rdata)
  );

  smc_div #(.PixelCountBits(PixelCountBits)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sum_blue  (rd_blue),
    .sum_green (rd_green),
    .sum_red   (rd_red),
    .count     (rd_count),
    .done      (div_done),
    .means     (div_means)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_range &&
              (in_data.cmd == CMD_ACCUM || in_data.cmd == CMD_PAINT)) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= (cmd_r == CMD_PAINT) ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= in_data.cmd;
      addr_r   <= in_data.label[AddrW-1:0];
      pix_r[0] <= in_data.in_blue;
      pix_r[1] <= in_data.in_green;
      pix_r[2] <= in_data.in_red;
    end
    if (state_r == S_HOLD && out_free) begin
      out_data_r <= div_means;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside a paint");

  a_out_from_paint: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_HOLD))
    else $error("result beat without a paint");

  a_write_idle_or_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_READ))
    else $error("memory write during divide");

endmodule
